### rtl/bszt_pkg.sv
// Package for the box versus wall segment zone test: widths, register indexes and stage types.
package bszt_pkg;

	// Coordinate width of the Q16.16 fields and registers.
	localparam int unsigned COORD_W = 32;
	// Width of a coordinate difference.
	localparam int unsigned DW = COORD_W + 1;
	// Width of a doubled difference compared against a box size.
	localparam int unsigned CW = COORD_W + 3;
	// Width of one product of two differences.
	localparam int unsigned PW = 2 * COORD_W + 2;
	// Width of the projection and cross product sums.
	localparam int unsigned TW = 2 * COORD_W + 6;
	// Number of box corners.
	localparam int unsigned NUM_CORNERS = 4;
	// Width of the configuration register index.
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_WALL_START_X = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WALL_START_Y = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_WALL_END_X   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_WALL_END_Y   = CFG_IDX_W'(3);

	typedef struct packed {
		logic signed [COORD_W-1:0] box_center_x;
		logic signed [COORD_W-1:0] box_center_y;
		logic [COORD_W-2:0]        box_width;
		logic [COORD_W-2:0]        box_height;
	} item_t;

	typedef struct packed {
		logic in_zone;
		logic in_zone_right;
	} result_t;

	// Box center relative to the wall start, the wall vector and the box size.
	typedef struct packed {
		logic signed [DW-1:0] ax;
		logic signed [DW-1:0] ay;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic [COORD_W-2:0]   w;
		logic [COORD_W-2:0]   h;
	} s1_t;

	// All products of the projection, cross product and squared length.
	typedef struct packed {
		logic signed [PW-1:0] ax_dx;
		logic signed [PW-1:0] ay_dy;
		logic signed [PW-1:0] w_dx;
		logic signed [PW-1:0] h_dy;
		logic signed [PW-1:0] ay_dx;
		logic signed [PW-1:0] ax_dy;
		logic signed [PW-1:0] h_dx;
		logic signed [PW-1:0] w_dy;
		logic signed [PW-1:0] dx_dx;
		logic signed [PW-1:0] dy_dy;
		logic                 end_in_box;
	} s2_t;

	// Partial sums shared by the four corners.
	typedef struct packed {
		logic signed [TW-1:0] bt;
		logic signed [TW-1:0] ut;
		logic signed [TW-1:0] vt;
		logic signed [TW-1:0] bc;
		logic signed [TW-1:0] uc;
		logic signed [TW-1:0] vc;
		logic signed [TW-1:0] len2x2;
		logic                 end_in_box;
	} s3_t;

	// Per-corner projection and cross product.
	typedef struct packed {
		logic [NUM_CORNERS-1:0][TW-1:0] t;
		logic [NUM_CORNERS-1:0][TW-1:0] c;
		logic signed [TW-1:0]           len2x2;
		logic                           end_in_box;
	} s4_t;

endpackage

### rtl/bszt_mul.sv
// Multiplier stage: forms every product of the corner tests and the wall end box check.
module bszt_mul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           v_s1,
	input  bszt_pkg::s1_t  d_s1,
	output logic           v_s2,
	output bszt_pkg::s2_t  d_s2
);

	bszt_pkg::s2_t nxt;
	logic signed [bszt_pkg::COORD_W-1:0] w_sg;
	logic signed [bszt_pkg::COORD_W-1:0] h_sg;
	logic signed [bszt_pkg::CW-1:0] w_l;
	logic signed [bszt_pkg::CW-1:0] h_l;
	logic signed [bszt_pkg::CW-1:0] sx_rel;
	logic signed [bszt_pkg::CW-1:0] sy_rel;
	logic signed [bszt_pkg::CW-1:0] ex_rel;
	logic signed [bszt_pkg::CW-1:0] ey_rel;
	logic s_in;
	logic e_in;

	assign w_sg = $signed({1'b0, d_s1.w});
	assign h_sg = $signed({1'b0, d_s1.h});
	assign w_l  = bszt_pkg::CW'(w_sg);
	assign h_l  = bszt_pkg::CW'(h_sg);

	// A wall end point lies in the box when twice its offset from the center is within the size.
	assign sx_rel = bszt_pkg::CW'(d_s1.ax) + bszt_pkg::CW'(d_s1.ax);
	assign sy_rel = bszt_pkg::CW'(d_s1.ay) + bszt_pkg::CW'(d_s1.ay);
	assign ex_rel = (bszt_pkg::CW'(d_s1.ax) - bszt_pkg::CW'(d_s1.dx)) <<< 1;
	assign ey_rel = (bszt_pkg::CW'(d_s1.ay) - bszt_pkg::CW'(d_s1.dy)) <<< 1;

	assign s_in = (-w_l <= sx_rel) && (sx_rel <= w_l) && (-h_l <= sy_rel) && (sy_rel <= h_l);
	assign e_in = (-w_l <= ex_rel) && (ex_rel <= w_l) && (-h_l <= ey_rel) && (ey_rel <= h_l);

	always_comb begin
		nxt.ax_dx      = bszt_pkg::PW'(d_s1.ax) * bszt_pkg::PW'(d_s1.dx);
		nxt.ay_dy      = bszt_pkg::PW'(d_s1.ay) * bszt_pkg::PW'(d_s1.dy);
		nxt.w_dx       = bszt_pkg::PW'(w_sg) * bszt_pkg::PW'(d_s1.dx);
		nxt.h_dy       = bszt_pkg::PW'(h_sg) * bszt_pkg::PW'(d_s1.dy);
		nxt.ay_dx      = bszt_pkg::PW'(d_s1.ay) * bszt_pkg::PW'(d_s1.dx);
		nxt.ax_dy      = bszt_pkg::PW'(d_s1.ax) * bszt_pkg::PW'(d_s1.dy);
		nxt.h_dx       = bszt_pkg::PW'(h_sg) * bszt_pkg::PW'(d_s1.dx);
		nxt.w_dy       = bszt_pkg::PW'(w_sg) * bszt_pkg::PW'(d_s1.dy);
		nxt.dx_dx      = bszt_pkg::PW'(d_s1.dx) * bszt_pkg::PW'(d_s1.dx);
		nxt.dy_dy      = bszt_pkg::PW'(d_s1.dy) * bszt_pkg::PW'(d_s1.dy);
		nxt.end_in_box = s_in || e_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		d_s2 <= nxt;
	end

endmodule

### rtl/bszt_sum.sv
// Adder stages: shared partial sums, then the projection and cross product of each corner.
module bszt_sum (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           v_s2,
	input  bszt_pkg::s2_t  d_s2,
	output logic           v_s4,
	output bszt_pkg::s4_t  d_s4
);

	logic v_s3;
	bszt_pkg::s3_t d_s3;
	bszt_pkg::s3_t nxt3;
	bszt_pkg::s4_t nxt4;

	always_comb begin
		nxt3.bt = (bszt_pkg::TW'(d_s2.ax_dx) + bszt_pkg::TW'(d_s2.ay_dy)) <<< 1;
		nxt3.ut = bszt_pkg::TW'(d_s2.w_dx) + bszt_pkg::TW'(d_s2.h_dy);
		nxt3.vt = bszt_pkg::TW'(d_s2.w_dx) - bszt_pkg::TW'(d_s2.h_dy);
		nxt3.bc = (bszt_pkg::TW'(d_s2.ay_dx) - bszt_pkg::TW'(d_s2.ax_dy)) <<< 1;
		nxt3.uc = bszt_pkg::TW'(d_s2.h_dx) - bszt_pkg::TW'(d_s2.w_dy);
		nxt3.vc = bszt_pkg::TW'(d_s2.h_dx) + bszt_pkg::TW'(d_s2.w_dy);
		nxt3.len2x2 = (bszt_pkg::TW'(d_s2.dx_dx) + bszt_pkg::TW'(d_s2.dy_dy)) <<< 1;
		nxt3.end_in_box = d_s2.end_in_box;
	end

	// Corners in order: low x low y, high x low y, high x high y, low x high y.
	always_comb begin
		nxt4.t[0] = d_s3.bt - d_s3.ut;
		nxt4.c[0] = d_s3.bc - d_s3.uc;
		nxt4.t[1] = d_s3.bt + d_s3.vt;
		nxt4.c[1] = d_s3.bc - d_s3.vc;
		nxt4.t[2] = d_s3.bt + d_s3.ut;
		nxt4.c[2] = d_s3.bc + d_s3.uc;
		nxt4.t[3] = d_s3.bt - d_s3.vt;
		nxt4.c[3] = d_s3.bc + d_s3.vc;
		nxt4.len2x2 = d_s3.len2x2;
		nxt4.end_in_box = d_s3.end_in_box;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		d_s3 <= nxt3;
		d_s4 <= nxt4;
	end

endmodule

### rtl/bszt_zone.sv
// Decision stage: corner zone signs, right-side bits and the registered result.
module bszt_zone (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               v_s4,
	input  bszt_pkg::s4_t      d_s4,
	output logic               v_s5,
	output bszt_pkg::result_t  res_s5
);

	logic [bszt_pkg::NUM_CORNERS-1:0] z;
	logic [bszt_pkg::NUM_CORNERS-1:0] n;
	logic [bszt_pkg::NUM_CORNERS-1:0] r;
	logic len_zero;
	logic zone;
	logic many_right;
	logic one_right;
	bszt_pkg::result_t nxt;

	assign len_zero = (d_s4.len2x2 == '0);

	always_comb begin
		for (int k = 0; k < bszt_pkg::NUM_CORNERS; k++) begin
			z[k] = !len_zero && !d_s4.t[k][bszt_pkg::TW-1] && (d_s4.t[k] != '0) &&
				($signed(d_s4.t[k]) < d_s4.len2x2);
			n[k] = len_zero || d_s4.t[k][bszt_pkg::TW-1];
			r[k] = d_s4.c[k][bszt_pkg::TW-1];
		end
	end

	assign zone       = !((z == '0) && ((n == '1) || (n == '0)));
	assign many_right = ($countones(r) > 1);
	assign one_right  = ($countones(r) == 1);

	always_comb begin
		nxt.in_zone       = zone;
		nxt.in_zone_right = zone && (many_right ||
			(one_right && (((r & z) != '0) || d_s4.end_in_box)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		res_s5 <= nxt;
	end

endmodule

### rtl/box_segment_zone_test_unit.sv
// Top level of the box versus wall segment zone test.
//
// A wall segment is loaded through the configuration channel: a transfer
// happens when cfg_valid and cfg_ready are both high, and cfg_index picks the
// register (0 start x, 1 start y, 2 end x, 3 end y; other indexes are ignored).
// cfg_ready is always high. Write the wall only while no box is in flight.
//
// A box is accepted at each rising edge where start is high and busy is low.
// busy never rises, so one box can be accepted in every clock cycle.
// The result appears on result with done high for exactly one cycle, after
// passing an input stage, a multiplier stage, two adder stages and a
// decision stage. The adder chain over the 70-bit projection sums sets the
// stage split. Throughput is one box per cycle.
//
// in_zone is low only when all four corners fall on the same side beyond the
// wall ends; in_zone_right also needs the box to reach the wall's right side.
// A zero-length wall gives zero on both.
//
// The receiver cannot hold results off, so no result is ever stalled.
// Reset clears the wall registers to zero and drops every item in flight.
module box_segment_zone_test_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  bszt_pkg::item_t                     item,
	output logic                                done,
	output bszt_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bszt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bszt_pkg::COORD_W-1:0]        cfg_data
);

	// Wall end points, signed Q16.16.
	logic signed [bszt_pkg::COORD_W-1:0] wall_sx_q;
	logic signed [bszt_pkg::COORD_W-1:0] wall_sy_q;
	logic signed [bszt_pkg::COORD_W-1:0] wall_ex_q;
	logic signed [bszt_pkg::COORD_W-1:0] wall_ey_q;

	logic          accept;
	logic          v_s1;
	bszt_pkg::s1_t d_s1;
	bszt_pkg::s1_t nxt1;
	logic          v_s2;
	bszt_pkg::s2_t d_s2;
	logic          v_s4;
	bszt_pkg::s4_t d_s4;

	// The pipeline never stalls, so both channels are always open.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_sx_q <= '0;
			wall_sy_q <= '0;
			wall_ex_q <= '0;
			wall_ey_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bszt_pkg::REG_WALL_START_X: wall_sx_q <= $signed(cfg_data);
				bszt_pkg::REG_WALL_START_Y: wall_sy_q <= $signed(cfg_data);
				bszt_pkg::REG_WALL_END_X:   wall_ex_q <= $signed(cfg_data);
				bszt_pkg::REG_WALL_END_Y:   wall_ey_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// The input stage keeps the box center relative to the wall start, so all later
	// arithmetic works on offsets and every corner test is linear in the box size.
	always_comb begin
		nxt1.ax = bszt_pkg::DW'(item.box_center_x) - bszt_pkg::DW'(wall_sx_q);
		nxt1.ay = bszt_pkg::DW'(item.box_center_y) - bszt_pkg::DW'(wall_sy_q);
		nxt1.dx = bszt_pkg::DW'(wall_ex_q) - bszt_pkg::DW'(wall_sx_q);
		nxt1.dy = bszt_pkg::DW'(wall_ey_q) - bszt_pkg::DW'(wall_sy_q);
		nxt1.w  = item.box_width;
		nxt1.h  = item.box_height;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= nxt1;
	end

	bszt_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.v_s1   (v_s1),
		.d_s1   (d_s1),
		.v_s2   (v_s2),
		.d_s2   (d_s2)
	);

	bszt_sum u_sum (
		.clk    (clk),
		.arst_n (arst_n),
		.v_s2   (v_s2),
		.d_s2   (d_s2),
		.v_s4   (v_s4),
		.d_s4   (d_s4)
	);

	// The decision stage register drives the result ports directly.
	bszt_zone u_zone (
		.clk    (clk),
		.arst_n (arst_n),
		.v_s4   (v_s4),
		.d_s4   (d_s4),
		.v_s5   (done),
		.res_s5 (result)
	);

endmodule

### rtl/bszt_checker.sv
// Port-level checker for the zone test unit and its bind to the top level.
module bszt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input bszt_pkg::result_t              result,
	input logic                           cfg_valid,
	input logic                           cfg_ready
);

	// Every accepted box yields a result with done high.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("accepted box produced no result");

	// No result without an earlier accepted box.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("result without an accepted box");

	// The right-side result implies the plain zone result.
	a_right_in_zone: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!result.in_zone_right || result.in_zone))
		else $error("in_zone_right set without in_zone");

	// A register write offered on the configuration channel is always taken.
	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind box_segment_zone_test_unit bszt_checker u_bszt_checker (.*);
